// ----- rtl/qrei_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrei_pkg
// shared constants for the quad / rectangle edge crossing block
// ---------------------------------------------------------------------------
package qrei_pkg;

    // default coordinate width, signed fixed point with four fraction bits
    localparam int QREI_COORD_BITS = 16;

    // edges of the quad and of the rectangle
    localparam int QREI_NUM_EDGES = 4;

endpackage
`default_nettype wire

// ----- rtl/qrei_seg_test.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// qrei_seg_test
// exact segment meet test of rectangle edge a-b against quad edge c-d
// ---------------------------------------------------------------------------
module qrei_seg_test #(
    parameter int COORD_BITS = qrei_pkg::QREI_COORD_BITS
) (
    input  logic signed [COORD_BITS:0]   i_ax,
    input  logic signed [COORD_BITS:0]   i_ay,
    input  logic signed [COORD_BITS:0]   i_bx,
    input  logic signed [COORD_BITS:0]   i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_dx,
    input  logic signed [COORD_BITS-1:0] i_dy,
    output logic                         o_meet
);
    import qrei_pkg::*;

    localparam int DW = COORD_BITS + 2;
    localparam int MW = 2 * DW;
    localparam int PW = MW + 1;

    logic signed [DW-1:0] w_abx, w_aby, w_cdx, w_cdy, w_cax, w_cay;
    logic signed [MW-1:0] w_p_den0, w_p_den1, w_p_na0, w_p_na1, w_p_nb0, w_p_nb1;
    logic signed [PW-1:0] w_den, w_na, w_nb;
    logic                 w_na_ok, w_nb_ok;

    // edge vectors, exact
    assign w_abx = DW'(i_bx) - DW'(i_ax);
    assign w_aby = DW'(i_by) - DW'(i_ay);
    assign w_cdx = DW'(i_dx) - DW'(i_cx);
    assign w_cdy = DW'(i_dy) - DW'(i_cy);
    assign w_cax = DW'(i_ax) - DW'(i_cx);
    assign w_cay = DW'(i_ay) - DW'(i_cy);

    // cross products
    assign w_p_den0 = w_cdy * w_abx;
    assign w_p_den1 = w_cdx * w_aby;
    assign w_p_na0  = w_cdx * w_cay;
    assign w_p_na1  = w_cdy * w_cax;
    assign w_p_nb0  = w_abx * w_cay;
    assign w_p_nb1  = w_aby * w_cax;

    assign w_den = PW'(w_p_den0) - PW'(w_p_den1);
    assign w_na  = PW'(w_p_na0) - PW'(w_p_na1);
    assign w_nb  = PW'(w_p_nb0) - PW'(w_p_nb1);

    // num/den in [0, 1]: between zero and den on the side of den's sign
    always_comb begin
        if (w_den > 0) begin
            w_na_ok = (w_na >= 0) && (w_na <= w_den);
            w_nb_ok = (w_nb >= 0) && (w_nb <= w_den);
        end else if (w_den < 0) begin
            w_na_ok = (w_na <= 0) && (w_na >= w_den);
            w_nb_ok = (w_nb <= 0) && (w_nb >= w_den);
        end else begin
            // parallel or degenerate edges never meet
            w_na_ok = 1'b0;
            w_nb_ok = 1'b0;
        end
    end

    assign o_meet = w_na_ok && w_nb_ok;

endmodule
`default_nettype wire

// ----- rtl/quad_rect_edge_intersection_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// quad_rect_edge_intersection_top
// reports whether any edge of an axis-aligned rectangle meets any quad edge
// ---------------------------------------------------------------------------
// Each item carries one quadrilateral (vertices 0..3, edges 0-1, 1-2, 2-3,
// 3-0) and one rectangle (left, top, width, height), all in signed fixed
// point with four fraction bits (width and height unsigned). The block
// tests all 16 pairs of rectangle edge and quad edge with exact integer
// cross products and no division, and sets o_edges_cross when any pair
// meets, end points included; parallel or zero-length edges count as not
// meeting, even when they overlap. Right is left plus width and bottom is
// top plus height, formed one bit wider so nothing wraps. One item is taken
// every cycle while the result side does not stall; each accepted item
// passes through one input register, then sixteen parallel segment-test
// lanes, each a row of multipliers and compares, then the result register.
// Both channels use valid/stall; a stalled result holds while a new item
// may still sit in the input register.
// ---------------------------------------------------------------------------
module quad_rect_edge_intersection_top #(
    parameter int COORD_BITS = qrei_pkg::QREI_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_quad_x0,
    input  logic signed [COORD_BITS-1:0] i_quad_y0,
    input  logic signed [COORD_BITS-1:0] i_quad_x1,
    input  logic signed [COORD_BITS-1:0] i_quad_y1,
    input  logic signed [COORD_BITS-1:0] i_quad_x2,
    input  logic signed [COORD_BITS-1:0] i_quad_y2,
    input  logic signed [COORD_BITS-1:0] i_quad_x3,
    input  logic signed [COORD_BITS-1:0] i_quad_y3,
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_top,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_edges_cross
);
    import qrei_pkg::*;

    localparam int NE = QREI_NUM_EDGES;

    // input register
    logic                         r_s1_valid;
    logic signed [COORD_BITS-1:0] r_qx [NE];
    logic signed [COORD_BITS-1:0] r_qy [NE];
    logic signed [COORD_BITS-1:0] r_left, r_top;
    logic        [COORD_BITS-2:0] r_width, r_height;

    // result register
    logic r_out_valid;
    logic r_edges_cross;
    logic n_edges_cross;

    logic w_advance;    // result register may take a new value
    logic w_load;       // input register takes the offered item

    assign w_advance = !r_out_valid || !i_stall;
    assign w_load    = !r_s1_valid || w_advance;
    assign o_stall   = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_s1_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_qx[0]  <= i_quad_x0;
            r_qy[0]  <= i_quad_y0;
            r_qx[1]  <= i_quad_x1;
            r_qy[1]  <= i_quad_y1;
            r_qx[2]  <= i_quad_x2;
            r_qy[2]  <= i_quad_y2;
            r_qx[3]  <= i_quad_x3;
            r_qy[3]  <= i_quad_y3;
            r_left   <= i_box_left;
            r_top    <= i_box_top;
            r_width  <= i_box_width;
            r_height <= i_box_height;
        end
        if (w_advance && r_s1_valid) begin
            r_edges_cross <= n_edges_cross;
        end
    end

    // rectangle corners at one extra bit
    logic signed [COORD_BITS:0] w_left, w_right, w_top, w_bottom;
    logic signed [COORD_BITS:0] w_bx [NE];  // corner x, clockwise from top-left
    logic signed [COORD_BITS:0] w_by [NE];

    assign w_left   = (COORD_BITS + 1)'(r_left);
    assign w_top    = (COORD_BITS + 1)'(r_top);
    assign w_right  = w_left + $signed({2'b00, r_width});
    assign w_bottom = w_top + $signed({2'b00, r_height});

    assign w_bx[0] = w_left;   assign w_by[0] = w_top;
    assign w_bx[1] = w_right;  assign w_by[1] = w_top;
    assign w_bx[2] = w_right;  assign w_by[2] = w_bottom;
    assign w_bx[3] = w_left;   assign w_by[3] = w_bottom;

    // one lane per pair of rectangle edge and quad edge
    logic [NE*NE-1:0] w_meet;

    for (genvar gr = 0; gr < NE; gr++) begin : g_box_edge
        for (genvar gq = 0; gq < NE; gq++) begin : g_quad_edge
            qrei_seg_test #(
                .COORD_BITS (COORD_BITS)
            ) u_seg (
                .i_ax   (w_bx[gr]),
                .i_ay   (w_by[gr]),
                .i_bx   (w_bx[(gr + 1) % NE]),
                .i_by   (w_by[(gr + 1) % NE]),
                .i_cx   (r_qx[gq]),
                .i_cy   (r_qy[gq]),
                .i_dx   (r_qx[(gq + 1) % NE]),
                .i_dy   (r_qy[(gq + 1) % NE]),
                .o_meet (w_meet[gr*NE + gq])
            );
        end
    end

    assign n_edges_cross = |w_meet;

    assign o_valid       = r_out_valid;
    assign o_edges_cross = r_edges_cross;

`ifndef SYNTHESIS
    // an accepted item lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted item not held in input register");

    // a held item moves to the result register when it frees up
    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (!r_out_valid || !i_stall)) |=> o_valid)
        else $error("item lost between input and result register");

    // a blocked item stays in the input register
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_stall) |=> r_s1_valid)
        else $error("stalled item dropped from input register");
`endif

endmodule
`default_nettype wire

// ----- bench/quad_rect_edge_intersection_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quad_rect_edge_intersection_top_tb
// self-checking bench for the quad / rectangle edge crossing block
// ---------------------------------------------------------------------------
// A short table of hand-built items comes first: degenerate and collinear
// edges, touching end points, boxes inside and around the quad, and the
// coordinate extremes. About 400 random items follow, mostly clustered
// around the box so that crossings and misses both occur often. Each item
// lacking a typed answer is run through an exact integer model of the 16
// segment tests, and every result that leaves the block is compared in
// order against the stored expectation. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
module quad_rect_edge_intersection_top_tb;

    localparam int CB = qrei_pkg::QREI_COORD_BITS;

    // one item: four quad vertices and the rectangle
    typedef struct packed {
        logic signed [CB-1:0] x0;
        logic signed [CB-1:0] y0;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
        logic signed [CB-1:0] x2;
        logic signed [CB-1:0] y2;
        logic signed [CB-1:0] x3;
        logic signed [CB-1:0] y3;
        logic signed [CB-1:0] left;
        logic signed [CB-1:0] top;
        logic        [CB-2:0] width;
        logic        [CB-2:0] height;
    } quad_box_t;

    // directed row: typed rows carry their answer, the rest use the model
    typedef struct packed {
        quad_box_t item;
        bit        typed;
        bit        want;
    } directed_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CB-1:0] i_quad_x0 = '0;
    logic signed [CB-1:0] i_quad_y0 = '0;
    logic signed [CB-1:0] i_quad_x1 = '0;
    logic signed [CB-1:0] i_quad_y1 = '0;
    logic signed [CB-1:0] i_quad_x2 = '0;
    logic signed [CB-1:0] i_quad_y2 = '0;
    logic signed [CB-1:0] i_quad_x3 = '0;
    logic signed [CB-1:0] i_quad_y3 = '0;
    logic signed [CB-1:0] i_box_left = '0;
    logic signed [CB-1:0] i_box_top = '0;
    logic        [CB-2:0] i_box_width = '0;
    logic        [CB-2:0] i_box_height = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_edges_cross;

    // expected crossing flags, oldest first
    bit            cross_expected_q[$];
    directed_row_t directed_q[$];
    int            mismatch_count = 0;
    // odds of an idle burst per item sent or per result cycle: 0 turns idling off
    int            idle_odds = 0;

    quad_rect_edge_intersection_top #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_quad_x0    (i_quad_x0),
        .i_quad_y0    (i_quad_y0),
        .i_quad_x1    (i_quad_x1),
        .i_quad_y1    (i_quad_y1),
        .i_quad_x2    (i_quad_x2),
        .i_quad_y2    (i_quad_y2),
        .i_quad_x3    (i_quad_x3),
        .i_quad_y3    (i_quad_y3),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edges_cross(o_edges_cross)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // exact crossing model
    // ------------------------------------------------------------------

    // true when num/den lies in [0, 1]; a zero denominator never passes
    function automatic bit ratio_in_unit(input longint num, input longint den);
        longint abs_num;
        longint abs_den;
        if (den == 0) return 1'b0;
        if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
        abs_num = (num < 0) ? -num : num;
        abs_den = (den < 0) ? -den : den;
        return abs_num <= abs_den;
    endfunction

    // segment a-b against segment c-d, end points included
    function automatic bit segs_meet(input longint ax, ay, bx, by, cx, cy, dx, dy);
        longint den;
        longint num_a;
        longint num_b;
        den   = (dy - cy) * (bx - ax) - (dx - cx) * (by - ay);
        num_a = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
        num_b = (bx - ax) * (ay - cy) - (by - ay) * (ax - cx);
        return ratio_in_unit(num_a, den) && ratio_in_unit(num_b, den);
    endfunction

    function automatic bit predict_edges_cross(input quad_box_t it);
        longint qx[4];
        longint qy[4];
        longint rx[4];
        longint ry[4];
        longint right;
        longint bottom;
        bit     hit;
        qx[0] = longint'(it.x0);
        qy[0] = longint'(it.y0);
        qx[1] = longint'(it.x1);
        qy[1] = longint'(it.y1);
        qx[2] = longint'(it.x2);
        qy[2] = longint'(it.y2);
        qx[3] = longint'(it.x3);
        qy[3] = longint'(it.y3);
        // corners clockwise from top left, right and bottom one bit wider
        right  = longint'($signed(it.left)) + longint'(it.width);
        bottom = longint'($signed(it.top)) + longint'(it.height);
        rx[0] = longint'(it.left);
        ry[0] = longint'(it.top);
        rx[1] = right;
        ry[1] = longint'(it.top);
        rx[2] = right;
        ry[2] = bottom;
        rx[3] = longint'(it.left);
        ry[3] = bottom;
        hit = 1'b0;
        for (int r = 0; r < 4; r++) begin
            for (int q = 0; q < 4; q++) begin
                if (segs_meet(rx[r], ry[r], rx[(r + 1) % 4], ry[(r + 1) % 4],
                              qx[q], qy[q], qx[(q + 1) % 4], qy[(q + 1) % 4]))
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input int x0, y0, x1, y1, x2, y2, x3, y3,
                           input int l, t, w, h, input bit typed, input bit want);
        directed_row_t row;
        row.item = '{x0: CB'(x0), y0: CB'(y0), x1: CB'(x1), y1: CB'(y1),
                     x2: CB'(x2), y2: CB'(y2), x3: CB'(x3), y3: CB'(y3),
                     left: CB'(l), top: CB'(t),
                     width: (CB - 1)'(w), height: (CB - 1)'(h)};
        row.typed = typed;
        row.want  = want;
        directed_q = {directed_q, row};
    endtask

    // clamp into the coordinate range, now and then snap to an extreme
    function automatic int coord_pick(input int v);
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 32767 : -32768;
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int size_pick(input int v);
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 32767 : 0;
        if (v > 32767) return 32767;
        if (v < 0) return 0;
        return v;
    endfunction

    function automatic quad_box_t make_random_item();
        quad_box_t it;
        int        vx[4];
        int        vy[4];
        int        l, t, w, h;
        int        cx, cy, spread, step;
        int        mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            // raw bits over the whole range
            for (int i = 0; i < 4; i++) begin
                vx[i] = int'($urandom_range(0, 65535)) - 32768;
                vy[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            l = int'($urandom_range(0, 65535)) - 32768;
            t = int'($urandom_range(0, 65535)) - 32768;
            w = $urandom_range(0, 32767);
            h = $urandom_range(0, 32767);
        end else if (mode < 5) begin
            // coarse grid: shared lines, touching corners and parallel edges
            step = $urandom_range(0, 1) ? 16 : 1;
            cx = int'($urandom_range(0, 2000)) - 1000;
            cy = int'($urandom_range(0, 2000)) - 1000;
            for (int i = 0; i < 4; i++) begin
                vx[i] = cx + step * (int'($urandom_range(0, 8)) - 4);
                vy[i] = cy + step * (int'($urandom_range(0, 8)) - 4);
            end
            l = cx + step * (int'($urandom_range(0, 8)) - 4);
            t = cy + step * (int'($urandom_range(0, 8)) - 4);
            w = step * $urandom_range(0, 8);
            h = step * $urandom_range(0, 8);
        end else begin
            // quad scattered around the box center
            cx = int'($urandom_range(0, 32000)) - 16000;
            cy = int'($urandom_range(0, 32000)) - 16000;
            spread = $urandom_range(16, 8000);
            w = $urandom_range(0, spread);
            h = $urandom_range(0, spread);
            l = cx - w / 2;
            t = cy - h / 2;
            for (int i = 0; i < 4; i++) begin
                vx[i] = cx + int'($urandom_range(0, 2 * spread)) - spread;
                vy[i] = cy + int'($urandom_range(0, 2 * spread)) - spread;
            end
        end
        it.x0 = CB'(coord_pick(vx[0]));
        it.y0 = CB'(coord_pick(vy[0]));
        it.x1 = CB'(coord_pick(vx[1]));
        it.y1 = CB'(coord_pick(vy[1]));
        it.x2 = CB'(coord_pick(vx[2]));
        it.y2 = CB'(coord_pick(vy[2]));
        it.x3 = CB'(coord_pick(vx[3]));
        it.y3 = CB'(coord_pick(vy[3]));
        it.left   = CB'(coord_pick(l));
        it.top    = CB'(coord_pick(t));
        it.width  = (CB - 1)'(size_pick(w));
        it.height = (CB - 1)'(size_pick(h));
        return it;
    endfunction

    // present one item, hold it through stalls, record its answer on accept
    task automatic send_item(input quad_box_t it, input bit want);
        int gap;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_quad_x0    <= it.x0;
        i_quad_y0    <= it.y0;
        i_quad_x1    <= it.x1;
        i_quad_y1    <= it.y1;
        i_quad_x2    <= it.x2;
        i_quad_y2    <= it.y2;
        i_quad_x3    <= it.x3;
        i_quad_y3    <= it.y3;
        i_box_left   <= it.left;
        i_box_top    <= it.top;
        i_box_width  <= it.width;
        i_box_height <= it.height;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        cross_expected_q = {cross_expected_q, want};
    endtask

    // ------------------------------------------------------------------
    // result side: random stall bursts, in-order compare
    // ------------------------------------------------------------------

    initial begin : result_stall
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (i_rst_n && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            i_stall <= (stall_left != 0);
        end
    end

    initial begin : result_check
        bit want;
        forever begin
            @(posedge i_clk);
            // values seen here are the ones present before the edge
            if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
                if (cross_expected_q.size() == 0) begin
                    $display("%0t: edges_cross expected none, got %0b", $time, o_edges_cross);
                    mismatch_count++;
                end else begin
                    want = cross_expected_q.pop_front();
                    if (o_edges_cross !== want) begin
                        $display("%0t: edges_cross expected %0b, got %0b",
                                 $time, want, o_edges_cross);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // everything zero: every edge has zero length
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
        // box straddles the quad's lower right corner
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, 80, 160, 160, 1'b1, 1'b1);
        // box well inside the quad: containment alone is no crossing
        add_row(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000, 0, 0, 16, 16,
                1'b1, 1'b0);
        // quad well inside the box
        add_row(-1000, -1000, 1000, -1000, 1000, 1000, -1000, 1000, -2000, -2000,
                4000, 4000, 1'b1, 1'b0);
        // quad far away from the box
        add_row(10000, 10000, 10160, 10000, 10160, 10160, 10000, 10160, 0, 0, 160, 160,
                1'b1, 1'b0);
        // flat quad lying on the box top edge: collinear overlap does not count
        add_row(32, 0, 128, 0, 128, 0, 32, 0, 0, 0, 160, 160, 1'b1, 1'b0);
        // point-sized box sitting on a quad edge
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, 0, 0, 0, 1'b1, 1'b0);
        // box corner touches a quad corner
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 160, 160, 16, 16, 1'b0, 1'b0);
        // zero-width box, a vertical line through the quad top edge
        add_row(0, 0, 160, 0, 160, 160, 0, 160, 80, -80, 0, 160, 1'b0, 1'b0);
        // diagonal quad edge passing exactly through a box corner
        add_row(-64, -64, 64, 64, 64, -64, -64, -64, 0, 0, 32, 32, 1'b0, 1'b0);
        // clockwise diamond cutting all four box sides
        add_row(0, -100, 100, 0, 0, 100, -100, 0, -60, -60, 120, 120, 1'b0, 1'b0);
        // full-range quad, box in the negative corner
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                -32768, -32768, 32767, 32767, 1'b0, 1'b0);
        // full-range quad, box growing past the coordinate range
        add_row(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                32767, 32767, 32767, 32767, 1'b0, 1'b0);
        // every field all ones
        add_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 32767, 32767, 1'b0, 1'b0);
        // long thin quad crossing the whole range, maximum edge lengths
        add_row(-32768, 32767, 32767, -32768, 32767, -32767, -32768, 32766,
                -32768, -32768, 32767, 32767, 1'b0, 1'b0);
        // single bits set in alternating patterns
        add_row(21845, -21846, -21846, 21845, 4369, -4370, -30584, 30583,
                -16384, 16384, 21845, 10922, 1'b0, 1'b0);

        idle_odds = 4;
        foreach (directed_q[n]) begin
            send_item(directed_q[n].item, directed_q[n].typed ? directed_q[n].want
                                                              : predict_edges_cross(directed_q[n].item));
        end

        // random part, idling changes every few dozen items, none at the tail
        for (int k = 0; k < 400; k++) begin
            quad_box_t it;
            if (k >= 360) idle_odds = 0;
            else if (k % 50 == 0) idle_odds = $urandom_range(0, 6);
            it = make_random_item();
            send_item(it, predict_edges_cross(it));
        end
        i_valid <= 1'b0;

        // drain, then keep watching for any stray result
        while (cross_expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin : run_limit
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/qrei_pkg.sv
rtl/qrei_seg_test.sv
rtl/quad_rect_edge_intersection_top.sv
bench/quad_rect_edge_intersection_top_tb.sv
